### sv/gda_pkg.sv
// Shared constants, tables and types for the Gregorian date arithmetic unit.
package gda_pkg;

    localparam int MIN_YEAR  = 1900;
    localparam int MAX_YEAR  = 2030;
    localparam int NUM_YEARS = MAX_YEAR - MIN_YEAR + 1;
    localparam int YI_W      = $clog2(NUM_YEARS);

    // Relative day numbers count from MIN_YEAR-01-01; absolute ones from FIRST_YEAR-01-01.
    localparam int REL_W      = 16;
    localparam int SER_W      = 18;
    localparam int FIRST_YEAR = 1601;

    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_SUB  = 2'd1;
    localparam logic [1:0] CMD_DIST = 2'd2;
    localparam logic [1:0] CMD_LESS = 2'd3;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam int DAYS_400 = 146097;
    localparam int DAYS_100 = 36524;
    localparam int DAYS_4   = 1461;
    localparam int DAYS_1   = 365;
    localparam int N4_LAST  = DAYS_100 / DAYS_4;
    localparam int RECIP_SH = 26;
    localparam int RECIP_4  = (1 << RECIP_SH) / DAYS_4;

    localparam logic [4:0] MDAYS [13] = '{5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                          5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};
    localparam logic [8:0] CUM_DAYS [13] = '{9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120,
                                             9'd151, 9'd181, 9'd212, 9'd243, 9'd273,
                                             9'd304, 9'd334};

    function automatic logic [NUM_YEARS-1:0] build_leap();
        logic [NUM_YEARS-1:0] v;
        int c4;
        int c100;
        int c400;
        c4   = MIN_YEAR % 4;
        c100 = MIN_YEAR % 100;
        c400 = MIN_YEAR % 400;
        for (int j = 0; j < NUM_YEARS; j++) begin
            v[j] = (c400 == 0) || ((c100 != 0) && (c4 == 0));
            c4   = (c4 == 3) ? 0 : c4 + 1;
            c100 = (c100 == 99) ? 0 : c100 + 1;
            c400 = (c400 == 399) ? 0 : c400 + 1;
        end
        return v;
    endfunction

    localparam logic [NUM_YEARS-1:0] LEAP_TAB = build_leap();

    function automatic logic [NUM_YEARS-1:0][REL_W-1:0] build_ystart();
        logic [NUM_YEARS-1:0][REL_W-1:0] v;
        int acc;
        acc = 0;
        for (int j = 0; j < NUM_YEARS; j++) begin
            v[j] = acc[REL_W-1:0];
            acc  = acc + DAYS_1 + (LEAP_TAB[j] ? 1 : 0);
        end
        return v;
    endfunction

    localparam logic [NUM_YEARS-1:0][REL_W-1:0] YSTART = build_ystart();

    // Days from FIRST_YEAR-01-01 to MIN_YEAR-01-01.
    function automatic int base_days();
        int acc;
        int c4;
        int c100;
        int c400;
        acc  = 0;
        c4   = FIRST_YEAR % 4;
        c100 = FIRST_YEAR % 100;
        c400 = FIRST_YEAR % 400;
        for (int y = FIRST_YEAR; y < MIN_YEAR; y++) begin
            acc  = acc + DAYS_1 + (((c400 == 0) || ((c100 != 0) && (c4 == 0))) ? 1 : 0);
            c4   = (c4 == 3) ? 0 : c4 + 1;
            c100 = (c100 == 99) ? 0 : c100 + 1;
            c400 = (c400 == 399) ? 0 : c400 + 1;
        end
        return acc;
    endfunction

    localparam logic [SER_W-1:0] BASE_SERIAL = SER_W'(base_days());

    typedef struct packed {
        logic [YI_W-1:0] idx;
        logic [3:0]      month;
        logic [4:0]      day;
    } t_date;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] span;
        logic        less;
    } t_side;

endpackage

### sv/gda_validate.sv
// Date validation and relative day number stages.
module gda_validate import gda_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_cmd,
    input  logic [11:0]      i_a_year,
    input  logic [3:0]       i_a_month,
    input  logic [4:0]       i_a_day,
    input  logic [15:0]      i_day_offset,
    input  logic [11:0]      i_b_year,
    input  logic [3:0]       i_b_month,
    input  logic [4:0]       i_b_day,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [1:0]       o_cmd,
    output logic [15:0]      o_day_offset,
    output logic [REL_W-1:0] o_serial_a,
    output logic [REL_W-1:0] o_serial_b
);

    function automatic t_date check_date(input logic [11:0] y, input logic [3:0] m,
                                         input logic [4:0] d);
        t_date           r;
        logic            in_rng;
        logic            m_ok;
        logic            lp;
        logic [11:0]     dy;
        logic [YI_W-1:0] idx;
        logic [3:0]      mc;
        logic [4:0]      mlen;
        in_rng = (y >= 12'(MIN_YEAR)) && (y <= 12'(MAX_YEAR));
        dy     = y - 12'(MIN_YEAR);
        idx    = in_rng ? dy[YI_W-1:0] : '0;
        m_ok   = (m >= MONTH_JAN) && (m <= MONTH_DEC);
        mc     = m_ok ? m : 4'd0;
        lp     = LEAP_TAB[idx];
        mlen   = MDAYS[mc] + {4'd0, (mc == MONTH_FEB) && lp};
        if (in_rng && m_ok && (d != 5'd0) && (d <= mlen)) begin
            r.idx   = idx;
            r.month = m;
            r.day   = d;
        end else begin
            r.idx   = '0;
            r.month = MONTH_JAN;
            r.day   = 5'd1;
        end
        return r;
    endfunction

    function automatic logic [REL_W-1:0] serial_of(input t_date dt);
        return YSTART[dt.idx] + REL_W'(CUM_DAYS[dt.month])
             + REL_W'((dt.month > MONTH_FEB) && LEAP_TAB[dt.idx])
             + REL_W'(dt.day) - REL_W'(1);
    endfunction

    logic        r1_v;
    logic [1:0]  r1_cmd;
    logic [15:0] r1_off;
    t_date       r1_a;
    t_date       r1_b;
    logic        r2_v;
    logic        rdy1;
    logic        rdy2;

    assign rdy2    = !r2_v || i_ready;
    assign rdy1    = !r1_v || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r2_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (rdy1) begin
            r1_v <= i_valid;
        end
        if (rdy1) begin
            r1_cmd <= i_cmd;
            r1_off <= i_day_offset;
            r1_a   <= check_date(i_a_year, i_a_month, i_a_day);
            r1_b   <= check_date(i_b_year, i_b_month, i_b_day);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (rdy2) begin
            r2_v <= r1_v;
        end
        if (rdy2) begin
            o_cmd        <= r1_cmd;
            o_day_offset <= r1_off;
            o_serial_a   <= serial_of(r1_a);
            o_serial_b   <= serial_of(r1_b);
        end
    end

endmodule

### sv/gda_ops.sv
// Command stage: shifted target day number, distance and order of the two dates.
module gda_ops import gda_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_cmd,
    input  logic [15:0]      i_day_offset,
    input  logic [REL_W-1:0] i_serial_a,
    input  logic [REL_W-1:0] i_serial_b,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [SER_W-1:0] o_serial,
    output t_side            o_side
);

    logic             r_v;
    logic [SER_W-1:0] n_serial;
    t_side            n_side;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;

    always_comb begin
        if (i_cmd == CMD_SUB) begin
            n_serial = BASE_SERIAL + SER_W'(i_serial_a) - SER_W'(i_day_offset);
        end else begin
            n_serial = BASE_SERIAL + SER_W'(i_serial_a) + SER_W'(i_day_offset);
        end
        n_side.cmd  = i_cmd;
        n_side.span = (i_serial_a > i_serial_b) ? 16'(i_serial_a - i_serial_b)
                                                : 16'(i_serial_b - i_serial_a);
        n_side.less = (i_serial_a < i_serial_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (o_ready) begin
            o_serial <= n_serial;
            o_side   <= n_side;
        end
    end

endmodule

### sv/gda_decode.sv
// Day number to calendar date: 400/100-year split, 4-year quotient, year and month stages.
module gda_decode import gda_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [SER_W-1:0] i_serial,
    input  t_side            i_side,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [11:0]      o_res_year,
    output logic [3:0]       o_res_month,
    output logic [4:0]       o_res_day,
    output logic [15:0]      o_day_distance,
    output logic             o_a_before_b
);

    localparam int NST = 5;

    logic [NST-1:0] r_v;
    logic [NST:0]   rdy;

    always_comb begin
        rdy[NST] = i_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_v[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage A: split off 400- and 100-year blocks.
    logic        r_a_n400;
    logic [1:0]  r_a_n100;
    logic [15:0] r_a_rem;
    t_side       r_a_side;
    logic        n_a_hi;
    logic [SER_W-1:0] n_a_r0;
    logic [1:0]  n_a_n100;
    logic [SER_W-1:0] n_a_r1;

    always_comb begin
        n_a_hi   = (i_serial >= SER_W'(DAYS_400));
        n_a_r0   = n_a_hi ? (i_serial - SER_W'(DAYS_400)) : i_serial;
        n_a_n100 = 2'((n_a_r0 >= SER_W'(DAYS_100)) ? 1 : 0)
                 + 2'((n_a_r0 >= SER_W'(2 * DAYS_100)) ? 1 : 0)
                 + 2'((n_a_r0 >= SER_W'(3 * DAYS_100)) ? 1 : 0);
        case (n_a_n100)
            2'd1:    n_a_r1 = n_a_r0 - SER_W'(DAYS_100);
            2'd2:    n_a_r1 = n_a_r0 - SER_W'(2 * DAYS_100);
            2'd3:    n_a_r1 = n_a_r0 - SER_W'(3 * DAYS_100);
            default: n_a_r1 = n_a_r0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_a_n400 <= n_a_hi;
            r_a_n100 <= n_a_n100;
            r_a_rem  <= n_a_r1[15:0];
            r_a_side <= i_side;
        end
    end

    // Stage B: reciprocal product for the 4-year quotient.
    logic        r_b_n400;
    logic [1:0]  r_b_n100;
    logic [15:0] r_b_rem;
    logic [31:0] r_b_prod;
    t_side       r_b_side;

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_b_n400 <= r_a_n400;
            r_b_n100 <= r_a_n100;
            r_b_rem  <= r_a_rem;
            r_b_prod <= 32'(r_a_rem) * 32'(RECIP_4);
            r_b_side <= r_a_side;
        end
    end

    // Stage C: quotient estimate and its multiple.
    logic        r_c_n400;
    logic [1:0]  r_c_n100;
    logic [15:0] r_c_rem;
    logic [4:0]  r_c_q;
    logic [15:0] r_c_qm;
    t_side       r_c_side;
    logic [4:0]  n_c_q;

    assign n_c_q = r_b_prod[RECIP_SH +: 5];

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_c_n400 <= r_b_n400;
            r_c_n100 <= r_b_n100;
            r_c_rem  <= r_b_rem;
            r_c_q    <= n_c_q;
            r_c_qm   <= 16'(n_c_q) * 16'(DAYS_4);
            r_c_side <= r_b_side;
        end
    end

    // Stage D: correct the quotient, split years, form the year and its leap flag.
    logic [11:0] r_d_year;
    logic        r_d_leap;
    logic [8:0]  r_d_doy;
    t_side       r_d_side;
    logic [15:0] n_d_r;
    logic [4:0]  n_d_n4;
    logic [10:0] n_d_r4;
    logic [1:0]  n_d_n1;
    logic [10:0] n_d_doy;
    logic [11:0] n_d_year;

    always_comb begin
        n_d_r = r_c_rem - r_c_qm;
        if (n_d_r >= 16'(DAYS_4)) begin
            n_d_n4 = r_c_q + 5'd1;
            n_d_r  = n_d_r - 16'(DAYS_4);
        end else begin
            n_d_n4 = r_c_q;
        end
        n_d_r4 = n_d_r[10:0];
        n_d_n1 = 2'((n_d_r4 >= 11'(DAYS_1)) ? 1 : 0)
               + 2'((n_d_r4 >= 11'(2 * DAYS_1)) ? 1 : 0)
               + 2'((n_d_r4 >= 11'(3 * DAYS_1)) ? 1 : 0);
        case (n_d_n1)
            2'd1:    n_d_doy = n_d_r4 - 11'(DAYS_1);
            2'd2:    n_d_doy = n_d_r4 - 11'(2 * DAYS_1);
            2'd3:    n_d_doy = n_d_r4 - 11'(3 * DAYS_1);
            default: n_d_doy = n_d_r4;
        endcase
        n_d_year = 12'(FIRST_YEAR) + (r_c_n400 ? 12'd400 : 12'd0)
                 + 12'(r_c_n100) * 12'd100 + {5'd0, n_d_n4, 2'b00} + 12'(n_d_n1);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_d_year <= n_d_year;
            // last year of a 4-year block is leap, except the century year not divisible by 400
            r_d_leap <= (n_d_n1 == 2'd3) && ((n_d_n4 != 5'(N4_LAST)) || (r_c_n100 == 2'd3));
            r_d_doy  <= n_d_doy[8:0];
            r_d_side <= r_c_side;
        end
    end

    // Stage E: month search and output register.
    logic [3:0] n_e_month;
    logic [8:0] n_e_before;
    logic [8:0] n_e_day;

    always_comb begin
        n_e_month = MONTH_JAN;
        for (int k = 2; k <= 12; k++) begin
            if (r_d_doy >= CUM_DAYS[k] + 9'((k > 2) && r_d_leap)) begin
                n_e_month = 4'(k);
            end
        end
        n_e_before = CUM_DAYS[n_e_month] + 9'((n_e_month > MONTH_FEB) && r_d_leap);
        n_e_day    = r_d_doy - n_e_before + 9'd1;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            if ((r_d_side.cmd == CMD_ADD) || (r_d_side.cmd == CMD_SUB)) begin
                o_res_year  <= r_d_year;
                o_res_month <= n_e_month;
                o_res_day   <= n_e_day[4:0];
            end else begin
                o_res_year  <= '0;
                o_res_month <= '0;
                o_res_day   <= '0;
            end
            o_day_distance <= (r_d_side.cmd == CMD_DIST) ? r_d_side.span : 16'd0;
            o_a_before_b   <= (r_d_side.cmd == CMD_LESS) && r_d_side.less;
        end
    end

`ifndef ASSERT_OFF
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_res_month != 4'd0) |-> (o_res_month <= MONTH_DEC) && (o_res_day != 5'd0))
        else $error("decoded month or day out of range");
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res_year) && $stable(o_day_distance))
        else $error("result changed while stalled");
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !((o_day_distance != 16'd0) && (o_res_month != 4'd0)) && !(o_a_before_b
        && ((o_day_distance != 16'd0) || (o_res_month != 4'd0))))
        else $error("more than one result kind set");
`endif

endmodule

### sv/gregorian_date_arithmetic_top.sv
// Top level of the Gregorian date arithmetic unit.
// Usage: present a command with date A, a day count and date B on the input
// channel (i_valid / o_ready); the item is taken when both are high. Each item
// gives exactly one result on the output channel (o_valid / i_ready).
// Invalid dates (year outside 1900..2030, bad month or day) count as 1900-01-01.
// Add and subtract return a date in o_res_*; distance returns o_day_distance;
// compare returns o_a_before_b; unused result fields read zero.
// Eight register stages: two validation/day number stages, one command stage
// and five calendar decode stages. One item enters per cycle while o_ready is
// high; the decode path needs two registered multiplies (reciprocal quotient
// by 1461 and its back product), which sets the depth.
// Reset clears all stage valid bits; no item is in flight afterwards.
// When the receiver holds i_ready low, the result holds and each stage holds
// its item once the stage after it is full; o_ready falls only when every
// stage is full, so no item is lost or repeated.
module gregorian_date_arithmetic_top import gda_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [11:0] i_a_year,
    input  logic [3:0]  i_a_month,
    input  logic [4:0]  i_a_day,
    input  logic [15:0] i_day_offset,
    input  logic [11:0] i_b_year,
    input  logic [3:0]  i_b_month,
    input  logic [4:0]  i_b_day,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_res_year,
    output logic [3:0]  o_res_month,
    output logic [4:0]  o_res_day,
    output logic [15:0] o_day_distance,
    output logic        o_a_before_b
);

    logic             v_valid;
    logic             v_ready;
    logic [1:0]       v_cmd;
    logic [15:0]      v_off;
    logic [REL_W-1:0] v_sa;
    logic [REL_W-1:0] v_sb;
    logic             p_valid;
    logic             p_ready;
    logic [SER_W-1:0] p_serial;
    t_side            p_side;

    gda_validate u_validate (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd        (i_cmd),
        .i_a_year     (i_a_year),
        .i_a_month    (i_a_month),
        .i_a_day      (i_a_day),
        .i_day_offset (i_day_offset),
        .i_b_year     (i_b_year),
        .i_b_month    (i_b_month),
        .i_b_day      (i_b_day),
        .o_valid      (v_valid),
        .i_ready      (v_ready),
        .o_cmd        (v_cmd),
        .o_day_offset (v_off),
        .o_serial_a   (v_sa),
        .o_serial_b   (v_sb)
    );

    gda_ops u_ops (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (v_valid),
        .o_ready      (v_ready),
        .i_cmd        (v_cmd),
        .i_day_offset (v_off),
        .i_serial_a   (v_sa),
        .i_serial_b   (v_sb),
        .o_valid      (p_valid),
        .i_ready      (p_ready),
        .o_serial     (p_serial),
        .o_side       (p_side)
    );

    gda_decode u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (p_valid),
        .o_ready        (p_ready),
        .i_serial       (p_serial),
        .i_side         (p_side),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_res_year     (o_res_year),
        .o_res_month    (o_res_month),
        .o_res_day      (o_res_day),
        .o_day_distance (o_day_distance),
        .o_a_before_b   (o_a_before_b)
    );

endmodule
